>>> hw/rtl/bvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvm_pkg;

    // Window and sample geometry.
    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 12;

    // Samples that remain once the smallest and largest are dropped.
    localparam int DIV = WINDOW - 2;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = $clog2(WINDOW * ((2 ** SAMPLE_BITS) - 1) + 1);

    // Division by DIV is a multiplication by a rounded-up reciprocal.
    // The extra four fraction bits keep the quotient exact for any divisor
    // up to fourteen and any trimmed sum that fits SUM_W bits.
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + DIV - 1) / DIV;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Largest trimmed sum the accumulator can produce.
    localparam int TRIM_MAX = DIV * ((2 ** SAMPLE_BITS) - 1);

    // Result field widths.
    localparam int AVG_W     = 12;
    localparam int LEVEL_W   = 4;
    localparam int LEVEL_MAX = 8;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FLD_W  = AVG_W + 1 + LEVEL_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [LEVEL_W-1:0]     t_level;

    // Thresholds for the two battery types.
    localparam t_sample LOW24  = t_sample'(1519);
    localparam t_sample FULL24 = t_sample'(1735);
    localparam t_sample STEP24 = t_sample'(27);
    localparam t_sample LOW12  = t_sample'(700);
    localparam t_sample FULL12 = t_sample'(844);
    localparam t_sample STEP12 = t_sample'(18);

    // Completed window passed from the accumulator to the grading stage.
    typedef struct packed {
        logic valid;
        t_sum sum;
    } t_trim_bus;

endpackage

`default_nettype wire

>>> hw/rtl/bvm_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module bvm_accum import bvm_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_sample   i_sample,
    output t_trim_bus      o_trim,
    input  wire logic      i_trim_ready
);

    logic    r_in_valid;
    t_sample r_in_sample;
    t_count  r_count;
    t_sum    r_sum;
    t_sample r_min;
    t_sample r_max;
    logic    r_trim_valid;
    t_sum    r_trim_sum;

    t_sum    n_sum;
    t_sample n_min;
    t_sample n_max;
    t_count  n_count;
    t_sum    n_trim;
    logic    s_full;
    logic    s_trim_free;
    logic    s_go;

    always_comb begin
        n_sum   = r_sum + t_sum'(r_in_sample);
        n_min   = (r_in_sample < r_min) ? r_in_sample : r_min;
        n_max   = (r_in_sample > r_max) ? r_in_sample : r_max;
        n_count = r_count + t_count'(1);
        n_trim  = n_sum - t_sum'(n_min) - t_sum'(n_max);
        s_full  = (n_count == t_count'(WINDOW));
        s_trim_free = !r_trim_valid || i_trim_ready;
        // A sample that does not close the window never waits on the next stage.
        s_go    = r_in_valid && (!s_full || s_trim_free);
        o_ready = !r_in_valid || s_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_count      <= '0;
            r_sum        <= '0;
            r_min        <= '1;
            r_max        <= '0;
            r_trim_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (s_go) begin
                if (s_full) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_min   <= '1;
                    r_max   <= '0;
                end else begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_min   <= n_min;
                    r_max   <= n_max;
                end
            end
            if (s_go && s_full) begin
                r_trim_valid <= 1'b1;
            end else if (i_trim_ready) begin
                r_trim_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_sample <= i_sample;
        end
        if (s_go && s_full) begin
            r_trim_sum <= n_trim;
        end
    end

    assign o_trim.valid = r_trim_valid;
    assign o_trim.sum   = r_trim_sum;

    // The count never rests at a full window: a full window restarts at once.
    a_count_below_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < t_count'(WINDOW))
        else $error("window count reached the window length");

    // Closing a window leaves an empty window behind it.
    a_window_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && s_full) |=> (r_count == '0 && r_sum == '0 && r_min == '1))
        else $error("window did not restart after completion");

    // With the extremes removed the sum cannot exceed DIV full-scale samples.
    a_trim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trim_valid |-> (r_trim_sum <= t_sum'(TRIM_MAX)))
        else $error("trimmed sum out of range");

endmodule

`default_nettype wire

>>> hw/rtl/bvm_grade.sv
`timescale 1ns / 1ps
`default_nettype none

module bvm_grade import bvm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_trim_bus         i_trim,
    output logic                   o_trim_ready,
    input  wire logic              i_battery_24v,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [AVG_W-1:0]       o_average,
    output logic                   o_supply_ok,
    output t_level                 o_level
);

    logic                 r_valid;
    logic [AVG_W-1:0]     r_average;
    logic                 r_ok;
    t_level               r_level;

    logic [PROD_W-1:0]    s_prod;
    t_sample              s_mean;
    t_sample              s_low;
    t_sample              s_full;
    t_sample              s_step;
    t_sample              s_diff;
    t_sample              s_mark;
    logic                 s_ok;
    t_level               s_count;
    t_level               n_level;

    always_comb begin
        s_prod = PROD_W'(i_trim.sum) * PROD_W'(RECIP);
        s_mean = s_prod[RECIP_SHIFT +: SAMPLE_BITS];

        if (i_battery_24v) begin
            s_low  = LOW24;
            s_full = FULL24;
            s_step = STEP24;
        end else begin
            s_low  = LOW12;
            s_full = FULL12;
            s_step = STEP12;
        end

        s_ok   = (s_mean >= s_low);
        s_diff = s_mean - s_low;

        // Truncating division of the headroom by the step: count the step
        // multiples it reaches. Below the full mark it reaches at most seven.
        s_count = '0;
        s_mark  = '0;
        for (int k = 1; k < LEVEL_MAX; k++) begin
            s_mark  = t_sample'(k) * s_step;
            s_count = s_count + t_level'(s_diff >= s_mark);
        end

        if (s_mean >= s_full) begin
            n_level = t_level'(LEVEL_MAX);
        end else if (s_ok) begin
            n_level = s_count;
        end else begin
            n_level = '0;
        end

        o_trim_ready = !r_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_trim_ready) begin
            r_valid <= i_trim.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_trim_ready && i_trim.valid) begin
            r_average <= AVG_W'(s_mean);
            r_ok      <= s_ok;
            r_level   <= n_level;
        end
    end

    assign o_valid     = r_valid;
    assign o_average   = r_average;
    assign o_supply_ok = r_ok;
    assign o_level     = r_level;

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_level <= t_level'(LEVEL_MAX)))
        else $error("charge level above full scale");

    a_low_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (r_level == '0))
        else $error("non-zero charge level on a low supply");

endmodule

`default_nettype wire

>>> hw/rtl/battery_voltage_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Battery voltage monitor. Each transaction on the slave stream carries one
// raw 12-bit ADC conversion of the divided battery voltage. Samples are
// gathered in windows of WINDOW (ten) samples; when a window closes, its
// smallest and largest samples are dropped and the rest are averaged with
// truncation to give the trimmed mean. One result transaction then leaves on
// the master stream, holding the mean, a supply-ok flag (mean at or above the
// low threshold) and a charge level from 0 to 8, and the next window starts
// empty. Windows that are still filling produce no output. The battery type
// register selects the thresholds: 24 V uses low 1519, full 1735 and a step
// of 27 codes per level; 12 V uses low 700, full 844 and a step of 18. The
// setting in force when the trimmed sum of a window is graded into the result
// register is the one that is used; it should be written only while no
// samples are in flight. The block takes one sample transaction in every
// clock cycle as long as results are being taken. Between the sample that
// closes a window and its result lie three register stages: input sample,
// trimmed window sum and result. While a result is stalled, the trimmed sum
// of the next window can still wait behind it; only a window-closing sample
// that finds both the trimmed-sum stage and the result register occupied is
// held back. Samples that do not close a window are always absorbed.

module battery_voltage_monitor import bvm_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // Sample stream.
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [11:0] sample, upper bits zero
    input  wire logic [IN_DATA_W-1:0]   i_s_axis_tdata,

    // Result stream.
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [11:0] trimmed_average, [12] supply_ok, [16:13] charge_level, upper bits zero
    output logic [OUT_DATA_W-1:0]       o_m_axis_tdata,

    // Battery type register write channel: 1 selects 24 V, 0 selects 12 V.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic                   i_cfg_data
);

    // The battery type register always accepts a write transaction.
    logic r_battery_24v;

    t_trim_bus        s_trim;
    logic             s_trim_ready;
    logic [AVG_W-1:0] s_average;
    logic             s_supply_ok;
    t_level           s_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery_24v <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_battery_24v <= i_cfg_data;
        end
    end

    // Window accumulation: running sum, minimum and maximum, and the
    // trimmed sum of each completed window.
    bvm_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_sample     (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_trim       (s_trim),
        .i_trim_ready (s_trim_ready)
    );

    // Mean, threshold comparison and charge level, with the result register.
    bvm_grade u_grade (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_trim        (s_trim),
        .o_trim_ready  (s_trim_ready),
        .i_battery_24v (r_battery_24v),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_average     (s_average),
        .o_supply_ok   (s_supply_ok),
        .o_level       (s_level)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({s_level, s_supply_ok, s_average});

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// The sample stream is driven one transaction at a time. Every accepted
// sample is also fed to a local model of the window and grading logic. Each
// result transaction is checked, field by field, against the oldest
// expectation waiting in the queue.
module tb;
    import bvm_pkg::*;

    // The settling time adds a margin on top of RESULT_LAT, the result latency.
    localparam int RESULT_LAT    = 2;
    localparam int SETTLE_CYCLES = RESULT_LAT + 6;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RESET_CYCLES  = 12;
    localparam int REPORT_MAX    = 10;
    localparam int WINDOWS_PER_SEGMENT = 12;

    // Result fields, declared from the highest bit down so that the packed
    // layout matches the result tdata word.
    typedef struct packed {
        t_level           level;
        logic             supply_ok;
        logic [AVG_W-1:0] avg;
    } voltage_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CFG
    } row_kind_e;

    // A row is either a register write or a run of identical samples. The
    // typed result, where there is one, belongs to the last sample of the run.
    typedef struct {
        row_kind_e       kind;
        int              value;
        int              count;
        bit              typed;
        voltage_result_t want;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_data = 1'b0;

    // State of the local window model and its copy of the battery type.
    logic        batt_24v = 1'b0;
    int unsigned win_count = 0;
    int unsigned win_sum = 0;
    int unsigned win_lo = (2 ** SAMPLE_BITS) - 1;
    int unsigned win_hi = 0;

    voltage_result_t pending_results[$];
    int              n_errors = 0;
    int              cycle_count = 0;
    int              src_idle_pct = 0;
    int              snk_idle_pct = 0;

    // Directed part. The first window trims away both extremes and leaves
    // a mean exactly on the 12 V low threshold. In the second window the
    // battery type changes to 24 V halfway through. At 12 V the same mean
    // would be graded as full, so the result shows that the later setting
    // was used.
    stim_row_t directed_rows [8] = '{
        '{ROW_CFG,    0,    1, 1'b0, '0},
        '{ROW_SAMPLE, 4095, 1, 1'b0, '0},
        '{ROW_SAMPLE, 0,    1, 1'b0, '0},
        '{ROW_SAMPLE, 700,  8, 1'b1, '{4'd0, 1'b1, 12'd700}},
        '{ROW_SAMPLE, 1519, 5, 1'b0, '0},
        '{ROW_CFG,    1,    1, 1'b0, '0},
        '{ROW_SAMPLE, 1519, 5, 1'b1, '{4'd0, 1'b1, 12'd1519}},
        '{ROW_SAMPLE, 4095, 10, 1'b1, '{4'd8, 1'b1, 12'd4095}}
    };

    battery_voltage_monitor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // This is the watchdog against a stalled handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Adds one sample to the window. When the window closes, the function
    // grades the trimmed mean and reports the result.
    function automatic bit absorb_sample(input t_sample s, output voltage_result_t res);
        int unsigned mean;
        int unsigned low;
        int unsigned full;
        int unsigned step;
        res = '0;
        win_sum += s;
        if (s < win_lo) begin
            win_lo = s;
        end
        if (s > win_hi) begin
            win_hi = s;
        end
        win_count++;
        if (win_count < WINDOW) begin
            return 1'b0;
        end
        mean = (win_sum - win_lo - win_hi) / DIV;
        if (batt_24v) begin
            low  = LOW24;
            full = FULL24;
            step = STEP24;
        end else begin
            low  = LOW12;
            full = FULL12;
            step = STEP12;
        end
        res.avg       = mean[AVG_W-1:0];
        res.supply_ok = (mean >= low);
        res.level     = res.supply_ok ? t_level'((mean - low) / step) : '0;
        if (mean >= full) begin
            res.level = t_level'(LEVEL_MAX);
        end
        win_count = 0;
        win_sum   = 0;
        win_lo    = (2 ** SAMPLE_BITS) - 1;
        win_hi    = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Offers one sample after a random gap and holds it until the
    // transaction completes. It then updates the window model.
    task automatic push_sample(input t_sample s, input bit use_typed,
                               input voltage_result_t typed_res);
        voltage_result_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'(s);
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        if (absorb_sample(s, predicted)) begin
            pending_results.push_back(use_typed ? typed_res : predicted);
        end
    endtask

    // The register is written only once the block has gone quiet. All
    // expected results must have been taken, and any partial-window sample
    // must have had time to settle.
    task automatic write_battery_type(input logic is_24v);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= is_24v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        batt_24v = is_24v;
    endtask

    // Builds one window of samples and sends it. Most windows are centred
    // on the grading range of one battery type, or sit within two codes of a level
    // boundary. Random outliers are added so that trimming has real work to
    // do. The remaining windows are uniform noise across the full code range.
    task automatic feed_window();
        t_sample     vals [WINDOW];
        int unsigned mode;
        int unsigned low;
        int unsigned full;
        int unsigned step;
        int unsigned centre;
        int unsigned pos;
        voltage_result_t no_res;
        no_res = '0;
        mode = $urandom_range(9);
        if ($urandom_range(1) != 0) begin
            low  = LOW24;
            full = FULL24;
            step = STEP24;
        end else begin
            low  = LOW12;
            full = FULL12;
            step = STEP12;
        end
        if (mode <= 2) begin
            foreach (vals[i]) begin
                vals[i] = t_sample'($urandom_range((2 ** SAMPLE_BITS) - 1));
            end
        end else if (mode <= 6) begin
            centre = $urandom_range(low - 40, full + 40);
            foreach (vals[i]) begin
                vals[i] = t_sample'(centre + $urandom_range(8) - 4);
            end
            pos = $urandom_range(WINDOW - 1);
            vals[pos] = t_sample'($urandom_range((2 ** SAMPLE_BITS) - 1));
        end else begin
            // Level boundaries run from the low threshold up to the full
            // mark in whole steps.
            centre = low + step * $urandom_range(8) + $urandom_range(4) - 2;
            foreach (vals[i]) begin
                vals[i] = t_sample'(centre);
            end
            pos = $urandom_range(WINDOW - 1);
            vals[pos] = t_sample'($urandom_range(centre));
            pos = $urandom_range(WINDOW - 1);
            vals[pos] = t_sample'($urandom_range(centre, (2 ** SAMPLE_BITS) - 1));
        end
        foreach (vals[i]) begin
            push_sample(vals[i], 1'b0, no_res);
        end
    endtask

    // Result side. A transaction completes at an edge where tvalid and
    // tready were both high. The values read just after the edge are the
    // ones that the edge sampled. tready is redrawn afterwards.
    initial begin
        voltage_result_t got;
        voltage_result_t want;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = voltage_result_t'(o_m_axis_tdata[OUT_FLD_W-1:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result avg=%0d ok=%0d level=%0d",
                        got.avg, got.supply_ok, got.level));
                end else begin
                    want = pending_results.pop_front();
                    if (got.avg !== want.avg || got.supply_ok !== want.supply_ok ||
                        got.level !== want.level) begin
                        report_mismatch($sformatf(
                            "result mismatch: expected avg=%0d ok=%0d level=%0d, got avg=%0d ok=%0d level=%0d",
                            want.avg, want.supply_ok, want.level,
                            got.avg, got.supply_ok, got.level));
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Stimulus: reset, then the directed table, then three random phases.
    // In the first phase the sender idles more lightly than the receiver.
    // In the second phase the balance is reversed. The last phase runs
    // flat out. Each phase is split in two so that both battery types are
    // exercised under every idling pattern.
    initial begin
        voltage_result_t no_res;
        bit              last_of_run;
        no_res = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_battery_type(directed_rows[r].value[0]);
            end else begin
                for (int k = 0; k < directed_rows[r].count; k++) begin
                    last_of_run = (k == directed_rows[r].count - 1);
                    push_sample(t_sample'(directed_rows[r].value),
                                directed_rows[r].typed && last_of_run,
                                directed_rows[r].want);
                end
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 36;
                    snk_idle_pct = 62;
                end
                1: begin
                    src_idle_pct = 62;
                    snk_idle_pct = 36;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int half = 0; half < 2; half++) begin
                write_battery_type(logic'((phase + half) % 2));
                repeat (WINDOWS_PER_SEGMENT) feed_window();
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> battery_voltage_monitor.f
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_accum.sv
hw/rtl/bvm_grade.sv
hw/rtl/battery_voltage_monitor.sv
tb/sv/tb.sv
